[hw/rtl/hsfd_pkg.sv]
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and the CRC-8 step for the humidity sensor frame
// decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    localparam logic [7:0]  CRC_POLY = 8'h31;
    localparam logic [7:0]  CRC_INIT = 8'hFF;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;

    localparam int unsigned OUT_DATA_W = 64;

    // One checked frame, handed from the front end to the conversion back end.
    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_humidity;
        logic        temp_crc_ok;
        logic        humidity_crc_ok;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_fifo_status;

    // Feed one byte into the CRC, MSB first, no reflection.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/humidity_sensor_frame_decoder_top.sv]
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_top
// Six-byte temperature/humidity frame decoder with CRC-8 check and
// conversion to hundredths of a degree C and of a percent.
// ----------------------------------------------------------------------------
// Feed the frame one byte per transfer: temperature high, temperature low,
// temperature CRC, humidity high, humidity low, humidity CRC. Set tuser on a
// byte to force it to be the first of a new frame. The CRC-8 uses polynomial
// 0x31, initial value 0xFF, no reflection, no final xor. One result transfer
// follows each sixth byte, also when a check fails (the failing flag and
// frame_ok are then low). The block takes one byte every cycle while the
// record queue has room; that rate is set by the front end, which runs the
// whole eight-bit CRC update for a byte combinationally. After its sixth
// byte is taken, a result passes through the record queue and the multiply
// stage into the output register. The record queue lets the front end keep
// taking bytes while results wait on the output; input tready drops only
// when the queue is full.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_top #(
    parameter int unsigned FIFO_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] frame_start
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [hsfd_pkg::OUT_DATA_W-1:0] o_m_tdata
        // [14:0] temp_centi_c, [28:15] humidity_centi, [44:29] raw_temp,
        // [60:45] raw_humidity, [61] temp_crc_ok, [62] humidity_crc_ok,
        // [63] frame_ok
);
    import hsfd_pkg::*;

    logic         s_accept;
    logic         push;
    logic         pop;
    t_frame_rec   push_rec;
    t_frame_rec   pop_rec;
    t_fifo_status fifo_st;

    // Hold off bytes only while the queue cannot take another record.
    assign o_s_tready = !fifo_st.full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    hsfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (i_s_tdata),
        .i_start  (i_s_tuser),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    hsfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_rec    (pop_rec),
        .o_status (fifo_st)
    );

    hsfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (fifo_st.nonempty),
        .i_rec       (pop_rec),
        .o_pop       (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

`ifndef SYNTHESIS
    // The front end never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && fifo_st.full))
        else $error("record pushed into full queue");

    // The back end pops only when a record is waiting.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> fifo_st.nonempty)
        else $error("record popped from empty queue");

    // A push with no pop leaves the queue non-empty next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> fifo_st.nonempty)
        else $error("pushed record lost");

    // Frame flag agrees with both check flags on a presented result.
    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[63] == (o_m_tdata[61] && o_m_tdata[62])))
        else $error("frame_ok inconsistent with check flags");
`endif

endmodule

[hw/rtl/hsfd_front.sv]
// ----------------------------------------------------------------------------
// hsfd_front
// Track the byte position, run the CRC and assemble both words; push one
// record per completed frame.
// ----------------------------------------------------------------------------
module hsfd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_start,
    output logic               o_push,
    output hsfd_pkg::t_frame_rec o_rec
);
    import hsfd_pkg::*;

    localparam logic [2:0] POS_TEMP_HI = 3'd0;
    localparam logic [2:0] POS_TEMP_LO = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI  = 3'd3;
    localparam logic [2:0] POS_HUM_LO  = 3'd4;
    localparam logic [2:0] POS_HUM_CRC = 3'd5;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic        r_tchk, n_tchk;

    logic [2:0]  pos;
    logic [7:0]  crc;
    logic        push;

    always_comb begin
        if (i_start || (r_pos > POS_HUM_CRC)) begin
            pos = POS_TEMP_HI;
            crc = CRC_INIT;
        end else begin
            pos = r_pos;
            crc = r_crc;
        end

        n_pos  = pos + 3'd1;
        n_crc  = crc;
        n_temp = r_temp;
        n_hum  = r_hum;
        n_tchk = r_tchk;
        push   = 1'b0;

        unique case (pos)
            POS_TEMP_HI: begin
                n_temp = {i_byte, r_temp[7:0]};
                n_crc  = crc8_update(crc, i_byte);
            end
            POS_TEMP_LO: begin
                n_temp = {r_temp[15:8], i_byte};
                n_crc  = crc8_update(crc, i_byte);
            end
            POS_TEMP_CRC: begin
                n_tchk = (crc == i_byte);
                n_crc  = CRC_INIT;
            end
            POS_HUM_HI: begin
                n_hum = {i_byte, r_hum[7:0]};
                n_crc = crc8_update(crc, i_byte);
            end
            POS_HUM_LO: begin
                n_hum = {r_hum[15:8], i_byte};
                n_crc = crc8_update(crc, i_byte);
            end
            default: begin
                push  = 1'b1;
                n_pos = POS_TEMP_HI;
                n_crc = CRC_INIT;
            end
        endcase
    end

    assign o_push                = i_accept && push;
    assign o_rec.raw_temp        = r_temp;
    assign o_rec.raw_humidity    = r_hum;
    assign o_rec.temp_crc_ok     = r_tchk;
    assign o_rec.humidity_crc_ok = (crc == i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_TEMP_HI;
            r_crc  <= CRC_INIT;
            r_temp <= '0;
            r_hum  <= '0;
            r_tchk <= 1'b0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_temp <= n_temp;
            r_hum  <= n_hum;
            r_tchk <= n_tchk;
        end
    end

endmodule

[hw/rtl/hsfd_fifo.sv]
// ----------------------------------------------------------------------------
// hsfd_fifo
// Short queue of frame records between the front end and the back end.
// ----------------------------------------------------------------------------
module hsfd_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  hsfd_pkg::t_frame_rec   i_rec,
    input  logic                   i_pop,
    output hsfd_pkg::t_frame_rec   o_rec,
    output hsfd_pkg::t_fifo_status o_status
);
    import hsfd_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_frame_rec       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_rec             = r_mem[r_rd_ptr];
    assign o_status.full     = (r_count == FULL_CNT);
    assign o_status.nonempty = (r_count != '0);

endmodule

[hw/rtl/hsfd_back.sv]
// ----------------------------------------------------------------------------
// hsfd_back
// Convert raw words to centi-units in two stages: multiply, then scale and
// offset into the output register.
// ----------------------------------------------------------------------------
module hsfd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rec_valid,
    input  hsfd_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [hsfd_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import hsfd_pkg::*;

    logic        r_s1_valid;
    t_frame_rec  r_s1_rec;
    logic [30:0] r_s1_tprod;
    logic [29:0] r_s1_hprod;

    logic        r_out_valid;
    logic [14:0] r_temp_centi;
    logic [13:0] r_hum_centi;
    t_frame_rec  r_out_rec;

    logic out_adv;
    logic s1_adv;

    assign out_adv = !r_out_valid || i_m_tready;
    assign s1_adv  = !r_s1_valid || out_adv;
    assign o_pop   = i_rec_valid && s1_adv;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_rec   <= i_rec;
            r_s1_tprod <= 31'(TEMP_SCALE) * 31'(i_rec.raw_temp);
            r_s1_hprod <= 30'(HUM_SCALE) * 30'(i_rec.raw_humidity);
        end
        if (out_adv && r_s1_valid) begin
            r_temp_centi <= r_s1_tprod[30:16] - TEMP_OFFSET;
            r_hum_centi  <= r_s1_hprod[29:16];
            r_out_rec    <= r_s1_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_rec_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_rec.temp_crc_ok && r_out_rec.humidity_crc_ok,
                         r_out_rec.humidity_crc_ok,
                         r_out_rec.temp_crc_ok,
                         r_out_rec.raw_humidity,
                         r_out_rec.raw_temp,
                         r_hum_centi,
                         r_temp_centi};

endmodule

[dv/humidity_sensor_frame_decoder_top_tb.sv]
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_top_tb
// Self-checking bench for the sensor frame decoder. Streams measurement frames
// byte by byte: a few hand-picked frames first, then random frames with
// occasional checksum corruption, cut-off frames and loose noise bytes. A
// scoreboard tracks the frame position and CRC on every accepted byte, queues
// the reading each sixth byte should produce and compares every result
// transfer field by field. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsfd_pkg::*;

    localparam int unsigned BYTE_TARGET    = 650;
    localparam int unsigned QUIET_FROM     = 560;  // no idling past this byte count
    localparam int unsigned DRAIN_AT       = 320;  // sender waits for all readings here
    localparam int unsigned STALL_LIMIT    = 500;  // cycles with no transfer on either side
    localparam int unsigned SETTLE_CYCLES  = 8;

    // Byte positions within one measurement frame.
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI   = 3'd3;
    localparam logic [2:0] POS_HUM_LO   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    // Result layout, lowest field last.
    typedef struct packed {
        logic        frame_ok;
        logic        humidity_crc_ok;
        logic        temp_crc_ok;
        logic [15:0] raw_humidity;
        logic [15:0] raw_temp;
        logic [13:0] humidity_centi;
        logic [14:0] temp_centi_c;
    } t_reading;

    // ------------------------------------------------------------------------
    // Scoreboard: follows the frame byte by byte and holds pending readings.
    // ------------------------------------------------------------------------
    class hsfd_scoreboard;
        logic [2:0]  pos;
        logic [7:0]  crc;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        temp_ok;
        t_reading    readings_q[$];
        int          errors;

        function new();
            pos       = POS_TEMP_HI;
            crc       = CRC_INIT;
            temp_word = '0;
            hum_word  = '0;
            temp_ok   = 1'b0;
            errors    = 0;
        endfunction

        // Shift one byte through the CRC register, MSB first.
        static function logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            repeat (8) begin
                r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            end
            return r;
        endfunction

        static function logic [7:0] word_crc(logic [15:0] w);
            return crc_byte(crc_byte(CRC_INIT, w[15:8]), w[7:0]);
        endfunction

        function int pending();
            return readings_q.size();
        endfunction

        // Advance the frame tracker by one accepted byte.
        function void note_byte(logic [7:0] b, logic start);
            logic [2:0]  p;
            logic        hum_ok;
            logic [31:0] t_prod;
            logic [31:0] h_prod;
            t_reading    r;
            p = pos;
            if (start || p > POS_HUM_CRC) begin
                p   = POS_TEMP_HI;
                crc = CRC_INIT;
            end
            case (p)
                POS_TEMP_HI: begin
                    temp_word[15:8] = b;
                    crc = crc_byte(crc, b);
                end
                POS_TEMP_LO: begin
                    temp_word[7:0] = b;
                    crc = crc_byte(crc, b);
                end
                POS_TEMP_CRC: begin
                    temp_ok = (crc == b);
                    crc     = CRC_INIT;
                end
                POS_HUM_HI: begin
                    hum_word[15:8] = b;
                    crc = crc_byte(crc, b);
                end
                POS_HUM_LO: begin
                    hum_word[7:0] = b;
                    crc = crc_byte(crc, b);
                end
                default: begin
                    hum_ok = (crc == b);
                    t_prod = 32'(TEMP_SCALE) * 32'(temp_word);
                    h_prod = 32'(HUM_SCALE) * 32'(hum_word);
                    r.temp_centi_c    = 15'((t_prod >> 16) - 32'(TEMP_OFFSET));
                    r.humidity_centi  = 14'(h_prod >> 16);
                    r.raw_temp        = temp_word;
                    r.raw_humidity    = hum_word;
                    r.temp_crc_ok     = temp_ok;
                    r.humidity_crc_ok = hum_ok;
                    r.frame_ok        = temp_ok & hum_ok;
                    readings_q.push_back(r);
                    pos = POS_TEMP_HI;
                    crc = CRC_INIT;
                    return;
                end
            endcase
            pos = p + 3'd1;
        endfunction

        // Compare one result transfer against the oldest pending reading.
        function void check_reading(logic [OUT_DATA_W-1:0] data);
            t_reading got;
            t_reading want;
            got = data;
            if (readings_q.size() == 0) begin
                $error("result 0x%h arrived with no reading pending", data);
                errors++;
                return;
            end
            want = readings_q.pop_front();
            if (got.temp_centi_c !== want.temp_centi_c) begin
                $error("temp_centi_c: expected %0d, actual %0d",
                       $signed(want.temp_centi_c), $signed(got.temp_centi_c));
                errors++;
            end
            if (got.humidity_centi !== want.humidity_centi) begin
                $error("humidity_centi: expected %0d, actual %0d",
                       want.humidity_centi, got.humidity_centi);
                errors++;
            end
            if (got.raw_temp !== want.raw_temp) begin
                $error("raw_temp: expected 0x%h, actual 0x%h", want.raw_temp, got.raw_temp);
                errors++;
            end
            if (got.raw_humidity !== want.raw_humidity) begin
                $error("raw_humidity: expected 0x%h, actual 0x%h",
                       want.raw_humidity, got.raw_humidity);
                errors++;
            end
            if (got.temp_crc_ok !== want.temp_crc_ok) begin
                $error("temp_crc_ok: expected %b, actual %b", want.temp_crc_ok, got.temp_crc_ok);
                errors++;
            end
            if (got.humidity_crc_ok !== want.humidity_crc_ok) begin
                $error("humidity_crc_ok: expected %b, actual %b",
                       want.humidity_crc_ok, got.humidity_crc_ok);
                errors++;
            end
            if (got.frame_ok !== want.frame_ok) begin
                $error("frame_ok: expected %b, actual %b", want.frame_ok, got.frame_ok);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block connections
    // ------------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata  = '0;   // [7:0] rx_byte
    logic                  i_s_tuser  = 1'b0; // [0] frame_start
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;         // [14:0] temp_centi_c, [28:15] humidity_centi,
                                              // [44:29] raw_temp, [60:45] raw_humidity,
                                              // [61] temp_crc_ok, [62] humidity_crc_ok,
                                              // [63] frame_ok

    bit          idle_en    = 1'b1;
    int unsigned bytes_sent = 0;
    int unsigned quiet_cycles = 0;
    hsfd_scoreboard sb = new();

    always #10 i_clk = ~i_clk;

    humidity_sensor_frame_decoder_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // ------------------------------------------------------------------------
    // Monitor: check a finished reading before noting a new byte. A reading
    // never leaves in the cycle its last byte is taken, so the order is safe.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                sb.check_reading(o_m_tdata);
            end
            if (i_s_tvalid && o_s_tready) begin
                sb.note_byte(i_s_tdata, i_s_tuser);
            end
        end
    end

    // Watchdog: end the run when neither side has moved a transfer for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: hold tready high for a while, then stall in short bursts.
    // ------------------------------------------------------------------------
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (idle_en && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------

    // Drive one byte and hold it until the transfer completes; an idle burst
    // may come first.
    task automatic send_byte(input logic [7:0] b, input logic start);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= start;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send a full frame; a nonzero error mask corrupts that word's checksum.
    task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                              input logic [7:0] t_err, input logic [7:0] h_err,
                              input logic start);
        send_byte(t[15:8], start);
        send_byte(t[7:0], 1'b0);
        send_byte(hsfd_scoreboard::word_crc(t) ^ t_err, 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(hsfd_scoreboard::word_crc(h) ^ h_err, 1'b0);
    endtask

    // Mostly random words, with the range ends now and then.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_crc_err();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    endfunction

    initial begin
        int unsigned sel;
        int unsigned n;
        bit          need_start;
        bit          drained;

        need_start = 1'b0;
        drained    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: range ends, back-to-back frames with no start flag, a
        // temperature checksum failure, a cut-off frame followed by a restart
        // with a humidity checksum failure.
        send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0);
        send_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b0);
        send_frame(16'h6666, 16'h8000, 8'hFF, 8'h00, 1'b1);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_frame(16'hBEEF, 16'h5A5A, 8'h00, 8'h01, 1'b1);

        // Random: mostly clean frames, some cut short, some stray bytes.
        while (bytes_sent < BYTE_TARGET) begin
            if (bytes_sent >= QUIET_FROM) begin
                idle_en = 1'b0;
            end
            if (!drained && bytes_sent >= DRAIN_AT) begin
                // Hold off until every pending reading has come out; let the
                // monitor note the last byte first.
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
                drained = 1'b1;
            end
            sel = $urandom_range(0, 19);
            if (sel < 14) begin
                send_frame(pick_word(), pick_word(), pick_crc_err(), pick_crc_err(),
                           need_start | 1'($urandom_range(0, 1)));
                need_start = 1'b0;
            end else if (sel < 17) begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    send_byte(8'($urandom_range(0, 255)),
                              (i == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
                end
                need_start = 1'b1;
            end else begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
                need_start = 1'b1;
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain and let the pipeline settle.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
